// File: rtl/core/line_intersection_point_unit_macros.svh
// Assertion macros for the line intersection point unit
`ifndef LINE_INTERSECTION_POINT_UNIT_MACROS_SVH
`define LINE_INTERSECTION_POINT_UNIT_MACROS_SVH
`ifndef SYNTH
`define LIP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lip assertion failed");
`define LIP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lip assertion failed");
`else
`define LIP_ASSERT_IMP(lbl, ante, cons)
`define LIP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/lip_pkg.sv
// Types and constants shared by the line intersection point unit
package lip_pkg;
    localparam int COORD_BITS   = 16;
    localparam int FIELD_W      = 16;
    localparam int OUT_W        = 32;
    localparam int CW           = COORD_BITS;
    localparam int DXW          = CW + 1;
    localparam int PRW          = 2 * CW + 2;
    localparam int PW           = 2 * CW + 1;
    localparam int DW           = 2 * CW + 3;
    localparam int MW           = PW + DXW;
    localparam int NW           = 3 * CW + 3;
    localparam int FIFO_DEPTH   = 8;
    localparam int FRONT_STAGES = 6;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [FIELD_W-1:0] line_a_start_x;
        logic signed [FIELD_W-1:0] line_a_start_y;
        logic signed [FIELD_W-1:0] line_a_end_x;
        logic signed [FIELD_W-1:0] line_a_end_y;
        logic signed [FIELD_W-1:0] line_b_start_x;
        logic signed [FIELD_W-1:0] line_b_start_y;
        logic signed [FIELD_W-1:0] line_b_end_x;
        logic signed [FIELD_W-1:0] line_b_end_y;
    } t_in_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
        logic                    lines_parallel;
        logic                    result_saturated;
    } t_out_word;

    typedef struct packed {
        logic             par;
        logic             neg_x;
        logic             neg_y;
        logic [DW-1:0]    dv;
        logic [NW-1:0]    mag_x;
        logic [NW-1:0]    mag_y;
        logic [OUT_W-1:0] px;
        logic [OUT_W-1:0] py;
    } t_job;

    typedef struct packed {
        logic             empty;
        logic [CNT_W-1:0] count;
    } t_fifo_stat;
endpackage

// File: rtl/core/lip_fifo.sv
// Job queue between the determinant front end and the divider back end
module lip_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lip_pkg::t_job     i_job,
    input  logic              i_pop,
    output logic              o_vld,
    output lip_pkg::t_job     o_job,
    output lip_pkg::t_fifo_stat o_stat
);
    import lip_pkg::*;

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    t_job             r_head;
    logic             r_head_vld;
    logic             pop_ok;

    assign pop_ok       = i_pop && (r_cnt != '0);
    assign o_job        = r_head;
    assign o_vld        = r_head_vld;
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (pop_ok) begin
            r_head <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
            r_head_vld <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt      <= r_cnt + CNT_W'(i_push) - CNT_W'(pop_ok);
            r_head_vld <= pop_ok;
        end
    end
endmodule

// File: rtl/core/lip_front.sv
// Front end: determinants, numerators, signs and magnitudes
module lip_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lip_pkg::t_in_word i_word,
    output logic              o_push,
    output lip_pkg::t_job     o_job
);
    import lip_pkg::*;

    logic signed [CW-1:0] c_ax0, c_ay0, c_ax1, c_ay1, c_bx0, c_by0, c_bx1, c_by1;

    logic [FRONT_STAGES-1:0] r_vld;

    logic signed [CW-1:0]  r1_ax0, r1_ay0, r1_ax1, r1_ay1, r1_bx0, r1_by0, r1_bx1, r1_by1;
    logic signed [DXW-1:0] r1_dx1, r1_dy1, r1_dx2, r1_dy2;

    logic signed [PRW-1:0] r2_m1, r2_m2;
    logic signed [PW-1:0]  r2_pa, r2_pb, r2_qa, r2_qb;
    logic signed [DXW-1:0] r2_dx1, r2_dy1, r2_dx2, r2_dy2;
    logic signed [CW-1:0]  r2_ax1, r2_ay1;

    logic signed [DW-1:0]  r3_den;
    logic signed [PW-1:0]  r3_p, r3_q;
    logic signed [DXW-1:0] r3_dx1, r3_dy1, r3_dx2, r3_dy2;
    logic signed [CW-1:0]  r3_ax1, r3_ay1;

    logic signed [MW-1:0]  r4_n1, r4_n2, r4_n3, r4_n4;
    logic signed [DW-1:0]  r4_den;
    logic signed [CW-1:0]  r4_ax1, r4_ay1;

    logic signed [NW-1:0]  r5_nx, r5_ny;
    logic signed [DW-1:0]  r5_den;
    logic signed [CW-1:0]  r5_ax1, r5_ay1;

    t_job r6_job;

    assign c_ax0 = i_word.line_a_start_x[CW-1:0];
    assign c_ay0 = i_word.line_a_start_y[CW-1:0];
    assign c_ax1 = i_word.line_a_end_x[CW-1:0];
    assign c_ay1 = i_word.line_a_end_y[CW-1:0];
    assign c_bx0 = i_word.line_b_start_x[CW-1:0];
    assign c_by0 = i_word.line_b_start_y[CW-1:0];
    assign c_bx1 = i_word.line_b_end_x[CW-1:0];
    assign c_by1 = i_word.line_b_end_y[CW-1:0];

    assign o_push = r_vld[FRONT_STAGES-1];
    assign o_job  = r6_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax0 <= c_ax0;
        r1_ay0 <= c_ay0;
        r1_ax1 <= c_ax1;
        r1_ay1 <= c_ay1;
        r1_bx0 <= c_bx0;
        r1_by0 <= c_by0;
        r1_bx1 <= c_bx1;
        r1_by1 <= c_by1;
        r1_dx1 <= DXW'(c_ax0) - DXW'(c_ax1);
        r1_dy1 <= DXW'(c_ay0) - DXW'(c_ay1);
        r1_dx2 <= DXW'(c_bx0) - DXW'(c_bx1);
        r1_dy2 <= DXW'(c_by0) - DXW'(c_by1);

        r2_m1  <= PRW'(r1_dx1) * PRW'(r1_dy2);
        r2_m2  <= PRW'(r1_dy1) * PRW'(r1_dx2);
        r2_pa  <= PW'(r1_ax0) * PW'(r1_ay1);
        r2_pb  <= PW'(r1_ay0) * PW'(r1_ax1);
        r2_qa  <= PW'(r1_bx0) * PW'(r1_by1);
        r2_qb  <= PW'(r1_bx1) * PW'(r1_by0);
        r2_dx1 <= r1_dx1;
        r2_dy1 <= r1_dy1;
        r2_dx2 <= r1_dx2;
        r2_dy2 <= r1_dy2;
        r2_ax1 <= r1_ax1;
        r2_ay1 <= r1_ay1;

        r3_den <= DW'(r2_m1) - DW'(r2_m2);
        r3_p   <= r2_pa - r2_pb;
        r3_q   <= r2_qa - r2_qb;
        r3_dx1 <= r2_dx1;
        r3_dy1 <= r2_dy1;
        r3_dx2 <= r2_dx2;
        r3_dy2 <= r2_dy2;
        r3_ax1 <= r2_ax1;
        r3_ay1 <= r2_ay1;

        r4_n1  <= MW'(r3_p) * MW'(r3_dx2);
        r4_n2  <= MW'(r3_dx1) * MW'(r3_q);
        r4_n3  <= MW'(r3_p) * MW'(r3_dy2);
        r4_n4  <= MW'(r3_dy1) * MW'(r3_q);
        r4_den <= r3_den;
        r4_ax1 <= r3_ax1;
        r4_ay1 <= r3_ay1;

        r5_nx  <= NW'(r4_n1) - NW'(r4_n2);
        r5_ny  <= NW'(r4_n3) - NW'(r4_n4);
        r5_den <= r4_den;
        r5_ax1 <= r4_ax1;
        r5_ay1 <= r4_ay1;

        r6_job.par   <= (r5_den == '0);
        r6_job.neg_x <= r5_nx[NW-1] ^ r5_den[DW-1];
        r6_job.neg_y <= r5_ny[NW-1] ^ r5_den[DW-1];
        r6_job.dv    <= r5_den[DW-1] ? DW'(-r5_den) : DW'(r5_den);
        r6_job.mag_x <= r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
        r6_job.mag_y <= r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
        r6_job.px    <= OUT_W'(r5_ax1);
        r6_job.py    <= OUT_W'(r5_ay1);
    end
endmodule

// File: rtl/core/lip_back.sv
// Back end: pipelined restoring divider, rounding and saturation
module lip_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  lip_pkg::t_job      i_job,
    output logic               o_done,
    output lip_pkg::t_out_word o_word
);
    import lip_pkg::*;

    localparam int EW = NW + OUT_W + 1;
    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        t_job          job;
        logic [DW-1:0] rem_x;
        logic [DW-1:0] rem_y;
        logic [NW-1:0] quo_x;
        logic [NW-1:0] quo_y;
    } t_div;

    function automatic t_div div_step(t_div s);
        logic [DW:0] tx;
        logic [DW:0] ty;
        t_div        r;
        r         = s;
        tx        = {s.rem_x, s.job.mag_x[NW-1]};
        ty        = {s.rem_y, s.job.mag_y[NW-1]};
        r.job.mag_x = s.job.mag_x << 1;
        r.job.mag_y = s.job.mag_y << 1;
        if (tx >= {1'b0, s.job.dv}) begin
            r.rem_x = DW'(tx - {1'b0, s.job.dv});
            r.quo_x = {s.quo_x[NW-2:0], 1'b1};
        end else begin
            r.rem_x = tx[DW-1:0];
            r.quo_x = {s.quo_x[NW-2:0], 1'b0};
        end
        if (ty >= {1'b0, s.job.dv}) begin
            r.rem_y = DW'(ty - {1'b0, s.job.dv});
            r.quo_y = {s.quo_y[NW-2:0], 1'b1};
        end else begin
            r.rem_y = ty[DW-1:0];
            r.quo_y = {s.quo_y[NW-2:0], 1'b0};
        end
        return r;
    endfunction

    // returns {saturated, value}
    function automatic logic [OUT_W:0] round_sat(logic [NW-1:0] quo, logic [DW-1:0] rem,
                                                 logic [DW-1:0] dv, logic neg);
        logic [NW:0]      qr;
        logic [EW-1:0]    qe;
        logic [EW-1:0]    lim;
        logic [OUT_W-1:0] v;
        logic             sat;
        qr  = {1'b0, quo} + (NW+1)'(rem >= (dv - rem));
        qe  = EW'(qr);
        lim = neg ? EW'(NEG_MAG) : EW'(POS_MAX);
        sat = (qe > lim);
        if (sat) begin
            v = neg ? NEG_MAG : POS_MAX;
        end else begin
            v = neg ? (OUT_W'(0) - qe[OUT_W-1:0]) : qe[OUT_W-1:0];
        end
        return {sat, v};
    endfunction

    t_div            n_stg [NW];
    t_div            r_stg [NW];
    logic [NW-1:0]   r_vld;
    t_div            head;
    t_div            last;
    logic [OUT_W:0]  fin_x;
    logic [OUT_W:0]  fin_y;
    t_out_word       n_out;
    t_out_word       r_out;
    logic            r_done;

    always_comb begin
        head       = '0;
        head.job   = i_job;
        n_stg[0]   = div_step(head);
        for (int s = 1; s < NW; s++) begin
            n_stg[s] = div_step(r_stg[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NW; s++) begin
            r_stg[s] <= n_stg[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[NW-2:0], i_vld};
            r_done <= r_vld[NW-1];
        end
    end

    assign last = r_stg[NW-1];

    always_comb begin
        fin_x = round_sat(last.quo_x, last.rem_x, last.job.dv, last.job.neg_x);
        fin_y = round_sat(last.quo_y, last.rem_y, last.job.dv, last.job.neg_y);
        if (last.job.par) begin
            n_out.cross_x          = last.job.px;
            n_out.cross_y          = last.job.py;
            n_out.lines_parallel   = 1'b1;
            n_out.result_saturated = 1'b0;
        end else begin
            n_out.cross_x          = fin_x[OUT_W-1:0];
            n_out.cross_y          = fin_y[OUT_W-1:0];
            n_out.lines_parallel   = 1'b0;
            n_out.result_saturated = fin_x[OUT_W] | fin_y[OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_word = r_out;
endmodule

// File: rtl/core/line_intersection_point_unit.sv
// Line intersection point unit: top level
// Path from accept to o_done: six front stages, the job queue (memory write, then head register),
// one divider stage per numerator bit, one output stage.
// Throughput: one word per cycle while busy is low; the divider pipeline pops the queue whenever it is not empty.
// Reset: synchronous, active low; clears valid bits and queue pointers only.
// Results are shown for one cycle on o_done; the receiver cannot stall.
module line_intersection_point_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lip_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_done,
    output lip_pkg::t_out_word o_word
);
    import lip_pkg::*;

    logic       accept;
    logic       push;
    t_job       push_job;
    t_job       head_job;
    logic       head_vld;
    logic       pop;
    t_fifo_stat fstat;

    assign busy   = (fstat.count >= CNT_W'(FIFO_DEPTH - FRONT_STAGES));
    assign accept = start && !busy;
    assign pop    = !fstat.empty;

    lip_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_word),
        .o_push   (push),
        .o_job    (push_job)
    );

    lip_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_vld   (head_vld),
        .o_job   (head_job),
        .o_stat  (fstat)
    );

    lip_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (head_vld),
        .i_job   (head_job),
        .o_done  (o_done),
        .o_word  (o_word)
    );

`include "line_intersection_point_unit_macros.svh"

    `LIP_ASSERT_IMP(a_fifo_bound, 1'b1, fstat.count <= CNT_W'(FIFO_DEPTH))
    `LIP_ASSERT_IMP(a_busy_needs_backlog, busy, !fstat.empty)
    `LIP_ASSERT_IMP(a_par_no_sat, o_done && o_word.lines_parallel, !o_word.result_saturated)
endmodule

// File: bench/tb.sv
// Self-checking testbench for the line intersection point unit
`timescale 1ns / 1ps

module tb;
    import lip_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    t_in_word   i_word;
    logic       busy;
    logic       o_done;
    t_out_word  o_word;

    t_out_word  pending_points[$];
    int         send_idle_pct;
    int         errors;
    int         words_sent;
    int         words_checked;
    int         parallel_seen;
    int         saturated_seen;
    int         cycle_count;

    line_intersection_point_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_word  (i_word),
        .busy    (busy),
        .o_done  (o_done),
        .o_word  (o_word)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // exact quotient, rounded half away from zero, clamped to 32 bits
    function automatic logic [31:0] round_quotient(logic signed [127:0] num,
                                                   logic signed [127:0] den,
                                                   inout logic sat);
        logic                neg;
        logic signed [127:0] n_mag;
        logic signed [127:0] d_mag;
        logic signed [127:0] quo;
        logic signed [127:0] rem;
        neg   = (num < 0) ^ (den < 0);
        n_mag = (num < 0) ? -num : num;
        d_mag = (den < 0) ? -den : den;
        quo   = n_mag / d_mag;
        rem   = n_mag % d_mag;
        if (rem >= d_mag - rem)
            quo = quo + 1;
        if (!neg) begin
            if (quo > 128'sd2147483647) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return quo[31:0];
        end
        if (quo > 128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(-quo);
    endfunction

    // low COORD_BITS bits of a field, sign-extended
    function automatic logic signed [127:0] coord(logic [15:0] raw);
        logic signed [COORD_BITS-1:0] v;
        v = raw[COORD_BITS-1:0];
        return 128'(v);
    endfunction

    function automatic t_out_word predict_crossing(t_in_word w);
        logic signed [127:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        logic signed [127:0] dx1, dy1, dx2, dy2, den, p, q, nx, ny;
        logic                sat;
        t_out_word           r;
        ax0 = coord(w.line_a_start_x);
        ay0 = coord(w.line_a_start_y);
        ax1 = coord(w.line_a_end_x);
        ay1 = coord(w.line_a_end_y);
        bx0 = coord(w.line_b_start_x);
        by0 = coord(w.line_b_start_y);
        bx1 = coord(w.line_b_end_x);
        by1 = coord(w.line_b_end_y);
        dx1 = ax0 - ax1;
        dy1 = ay0 - ay1;
        dx2 = bx0 - bx1;
        dy2 = by0 - by1;
        den = dx1 * dy2 - dy1 * dx2;
        r   = '0;
        if (den == 0) begin
            r.cross_x        = 32'(ax1);
            r.cross_y        = 32'(ay1);
            r.lines_parallel = 1'b1;
            return r;
        end
        p   = ax0 * ay1 - ay0 * ax1;
        q   = bx0 * by1 - bx1 * by0;
        nx  = p * dx2 - dx1 * q;
        ny  = p * dy2 - dy1 * q;
        sat = 1'b0;
        r.cross_x          = round_quotient(nx, den, sat);
        r.cross_y          = round_quotient(ny, den, sat);
        r.result_saturated = sat;
        return r;
    endfunction

    // start is left high after acceptance so back-to-back words need no toggling
    task automatic send_word(t_in_word w);
        i_word <= w;
        start  <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        pending_points.push_back(predict_crossing(w));
        words_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_in_word make_word(int ax0, int ay0, int ax1, int ay1,
                                           int bx0, int by0, int bx1, int by1);
        t_in_word w;
        w.line_a_start_x = 16'(ax0);
        w.line_a_start_y = 16'(ay0);
        w.line_a_end_x   = 16'(ax1);
        w.line_a_end_y   = 16'(ay1);
        w.line_b_start_x = 16'(bx0);
        w.line_b_start_y = 16'(by0);
        w.line_b_end_x   = 16'(bx1);
        w.line_b_end_y   = 16'(by1);
        return w;
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    always @(negedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_done) begin
            words_checked++;
            if (o_word.lines_parallel)
                parallel_seen++;
            if (o_word.result_saturated)
                saturated_seen++;
            if (pending_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected word %h", $time, o_word);
            end else begin
                exp_w = pending_points.pop_front();
                if (o_word.cross_x !== exp_w.cross_x) begin
                    errors++;
                    $display("%0t: cross_x exp %0d got %0d", $time,
                             exp_w.cross_x, o_word.cross_x);
                end
                if (o_word.cross_y !== exp_w.cross_y) begin
                    errors++;
                    $display("%0t: cross_y exp %0d got %0d", $time,
                             exp_w.cross_y, o_word.cross_y);
                end
                if (o_word.lines_parallel !== exp_w.lines_parallel) begin
                    errors++;
                    $display("%0t: lines_parallel exp %b got %b", $time,
                             exp_w.lines_parallel, o_word.lines_parallel);
                end
                if (o_word.result_saturated !== exp_w.result_saturated) begin
                    errors++;
                    $display("%0t: result_saturated exp %b got %b", $time,
                             exp_w.result_saturated, o_word.result_saturated);
                end
            end
        end
    end

    task automatic test_directed();
        send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(0, 0, 4, 4, 0, 4, 4, 0));
        send_word(make_word(0, 0, 1, 2, 0, 1, 5, 1));
        send_word(make_word(0, 0, -1, 2, 0, 1, 5, 1));
        send_word(make_word(0, 0, 1, -2, 0, -1, 5, -1));
        send_word(make_word(1, 1, 5, 5, 2, 2, 9, 9));
        send_word(make_word(1, 1, 5, 5, 0, 3, 4, 7));
        send_word(make_word(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_word(make_word(-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767));
        send_word(make_word(32767, 32767, -32768, -32767, 32767, 32766, -32768, -32768));
        send_word(make_word(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
        send_word(make_word(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_word(make_word(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        send_word(make_word(0, 0, 32767, 1, 0, 1, 32767, 0));
        send_word(make_word(0, 0, -32768, 1, 0, 1, -32768, 0));
        send_word(make_word(-32768, 32767, 0, 0, 5, -3, 5, 7));
        send_word(make_word(3, 0, 3, 9, 0, -2, 8, -2));
        send_word(make_word(0, 0, 3, 1, 0, 1, 3, 0));
    endtask

    task automatic test_random(int count, int idle_pct);
        t_in_word w;
        int       kind;
        int       sx, sy;
        send_idle_pct = idle_pct;
        repeat (count) begin
            w    = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
            kind = $urandom_range(99);
            if (kind < 15) begin
                // line B runs along line A's direction, or collapses to a single point
                sx = $urandom_range(4) == 0 ? 0 : int'($signed(w.line_b_start_x)) % 4000;
                w.line_b_end_x = 16'(int'($signed(w.line_b_start_x))
                    + int'($signed(w.line_a_end_x)) - int'($signed(w.line_a_start_x)));
                w.line_b_end_y = 16'(int'($signed(w.line_b_start_y))
                    + int'($signed(w.line_a_end_y)) - int'($signed(w.line_a_start_y)));
                if (sx == 0)
                    w.line_b_end_x = w.line_b_start_x;
                if (sx == 0)
                    w.line_b_end_y = w.line_b_start_y;
            end else if (kind < 35) begin
                // nearly parallel: tiny determinant, far-away crossing
                sx = $urandom_range(2) - 1;
                sy = $urandom_range(2) - 1;
                w.line_b_end_x = 16'(int'($signed(w.line_b_start_x))
                    + int'($signed(w.line_a_end_x)) - int'($signed(w.line_a_start_x)) + sx);
                w.line_b_end_y = 16'(int'($signed(w.line_b_start_y))
                    + int'($signed(w.line_a_end_y)) - int'($signed(w.line_a_start_y)) + sy);
            end else if (kind < 55) begin
                // small coordinates make rounding ties common
                w = make_word($urandom_range(16) - 8, $urandom_range(16) - 8,
                              $urandom_range(16) - 8, $urandom_range(16) - 8,
                              $urandom_range(16) - 8, $urandom_range(16) - 8,
                              $urandom_range(16) - 8, $urandom_range(16) - 8);
            end
            send_word(w);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_word         = '0;
        errors         = 0;
        words_sent     = 0;
        words_checked  = 0;
        parallel_seen  = 0;
        saturated_seen = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(500, 18);
        test_random(500, 66);
        test_random(500, 0);
        start <= 1'b0;

        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words, checked %0d results", words_sent, words_checked);
        $display("Results: %0d parallel, %0d saturated, %0d mismatches",
                 parallel_seen, saturated_seen, errors);
        if (errors == 0 && pending_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
